// File: rtl/qerc_pkg.sv
`timescale 1ns / 1ps

package qerc_pkg;

  localparam int COUNT_WIDTH_DEF   = 32;
  localparam int NUM_ENC           = 3;
  localparam int SCALE_WIDTH       = 16;
  localparam int SPEED_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH   = 2;

  localparam logic [SCALE_WIDTH-1:0] TPM_RESET = 16'd6000;
  localparam logic [SCALE_WIDTH-1:0] CPR_RESET = 16'd720;

  localparam logic [1:0] MODE_EDGE_A = 2'd0;
  localparam logic [1:0] MODE_EDGE_B = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TPM = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CPR = 2'd1;

  localparam logic signed [SPEED_WIDTH-1:0] SPEED_POS_SAT = 16'sh7FFF;
  localparam logic signed [SPEED_WIDTH-1:0] SPEED_NEG_SAT = 16'sh8000;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] channel;
    logic       level_a;
    logic       level_b;
  } evt_item_t;

  typedef struct packed {
    logic signed [SPEED_WIDTH-1:0] speed_0;
    logic signed [SPEED_WIDTH-1:0] speed_1;
    logic signed [SPEED_WIDTH-1:0] speed_2;
  } spd_item_t;

  typedef struct packed {
    logic [SCALE_WIDTH-1:0] ticks_per_minute;
    logic [SCALE_WIDTH-1:0] counts_per_rev;
  } scale_t;

endpackage

// File: rtl/qerc_speed_unit.sv
`timescale 1ns / 1ps

module qerc_speed_unit #(
  parameter int COUNT_WIDTH = qerc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  logic [COUNT_WIDTH-1:0]                     count,
  input  qerc_pkg::scale_t                           scale,
  output logic                                       done,
  output logic signed [qerc_pkg::SPEED_WIDTH-1:0]    speed
);
  import qerc_pkg::*;

  localparam int PROD_WIDTH = COUNT_WIDTH + SCALE_WIDTH;
  localparam int QUOT_WIDTH = SPEED_WIDTH - 1;
  localparam int MUL_STEPS  = SCALE_WIDTH;
  localparam int DIV_STEPS  = QUOT_WIDTH + 1;
  localparam int MAX_STEPS  = (MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS;
  localparam int STEP_W     = $clog2(MAX_STEPS);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_STEPS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} state_t;

  state_t                  state;
  logic                    neg;
  logic [PROD_WIDTH-1:0]   acc;
  logic [PROD_WIDTH-1:0]   mcand;
  logic [SCALE_WIDTH-1:0]  mult;
  logic [PROD_WIDTH-1:0]   dvs;
  logic [QUOT_WIDTH-1:0]   quot;
  logic [STEP_W-1:0]       step;

  logic [COUNT_WIDTH-1:0]  mag;
  logic [PROD_WIDTH-1:0]   opnd;
  logic                    cin;
  logic [PROD_WIDTH:0]     sum;
  logic                    ge;
  logic [QUOT_WIDTH-1:0]   quot_next;
  logic [SPEED_WIDTH-1:0]  quot_ext;

  // one adder: accumulate for the multiply, trial subtract for the divide
  always_comb begin
    mag       = count[COUNT_WIDTH-1] ? (~count + COUNT_WIDTH'(1)) : count;
    opnd      = (state == S_DIV) ? ~dvs : mcand;
    cin       = (state == S_DIV);
    sum       = {1'b0, acc} + {1'b0, opnd} + (PROD_WIDTH + 1)'(cin);
    ge        = sum[PROD_WIDTH];
    quot_next = {quot[QUOT_WIDTH-2:0], ge};
    quot_ext  = {1'b0, quot_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            neg   <= count[COUNT_WIDTH-1];
            acc   <= '0;
            mcand <= PROD_WIDTH'(mag);
            mult  <= scale.ticks_per_minute;
            dvs   <= PROD_WIDTH'({scale.counts_per_rev, QUOT_WIDTH'(0)});
            quot  <= '0;
            step  <= '0;
            if (mag == '0) begin
              speed <= '0;
              done  <= 1'b1;
            end else if (scale.counts_per_rev == '0) begin
              speed <= count[COUNT_WIDTH-1] ? SPEED_NEG_SAT : SPEED_POS_SAT;
              done  <= 1'b1;
            end else begin
              done  <= 1'b0;
              state <= S_MUL;
            end
          end else begin
            done <= 1'b0;
          end
        end
        S_MUL: begin
          done <= 1'b0;
          if (mult[0]) begin
            acc <= sum[PROD_WIDTH-1:0];
          end
          mcand <= {mcand[PROD_WIDTH-2:0], 1'b0};
          mult  <= {1'b0, mult[SCALE_WIDTH-1:1]};
          step  <= (step == MUL_LAST) ? '0 : step + STEP_W'(1);
          if (step == MUL_LAST) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // first trial against divisor << 15 decides saturation
          if (step == '0 && ge) begin
            speed <= neg ? SPEED_NEG_SAT : SPEED_POS_SAT;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            if (ge) begin
              acc <= sum[PROD_WIDTH-1:0];
            end
            quot <= quot_next;
            dvs  <= {1'b0, dvs[PROD_WIDTH-1:1]};
            step <= step + STEP_W'(1);
            done <= (step == DIV_LAST);
            if (step == DIV_LAST) begin
              speed <= neg ? -quot_ext : quot_ext;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/quad_encoder_rpm_counter_top.sv
`timescale 1ns / 1ps

// channel  signals                           item
// evt      evt_valid / evt_ready / evt       mode, channel, level_a, level_b
// spd      spd_valid / spd_ready / spd       speed_0, speed_1, speed_2
// cfg      cfg_valid / cfg_ready / cfg_index, cfg_data   register write
//
// Edge items are taken only while idle. A tick runs three passes of one shared
// adder, each 16 shift-add multiply steps and up to 16 restoring divide steps.
// Reset clears counts and state and loads default scale registers.
// Edge items are taken while a result waits on spd; a tick waits before output.

module quad_encoder_rpm_counter_top #(
  parameter int COUNT_WIDTH = qerc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   evt_valid,
  output logic                                   evt_ready,
  input  qerc_pkg::evt_item_t                    evt,
  output logic                                   spd_valid,
  input  logic                                   spd_ready,
  output qerc_pkg::spd_item_t                    spd,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [qerc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [qerc_pkg::SCALE_WIDTH-1:0]       cfg_data
);
  import qerc_pkg::*;

  localparam int CH_W = $clog2(NUM_ENC);
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_ENC - 1);

  typedef enum logic [1:0] {T_IDLE, T_START, T_WAIT, T_OUT} state_t;

  state_t                         state;
  logic [CH_W-1:0]                ch_idx;
  logic                           start;
  logic [COUNT_WIDTH-1:0]         counts [NUM_ENC];
  logic [COUNT_WIDTH-1:0]         snap   [NUM_ENC];
  logic signed [SPEED_WIDTH-1:0]  res    [NUM_ENC];
  scale_t                         scale;

  logic                           evt_acc;
  logic                           up;
  logic [COUNT_WIDTH-1:0]         delta;
  logic                           unit_done;
  logic signed [SPEED_WIDTH-1:0]  unit_speed;

  assign cfg_ready = 1'b1;
  assign evt_ready = (state == T_IDLE);
  assign evt_acc   = evt_valid && evt_ready;
  assign up        = (evt.mode == MODE_EDGE_A) ? (evt.level_a == evt.level_b)
                                               : (evt.level_a != evt.level_b);
  assign delta     = up ? COUNT_WIDTH'(1) : '1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale.ticks_per_minute <= TPM_RESET;
      scale.counts_per_rev   <= CPR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TPM: scale.ticks_per_minute <= cfg_data;
        REG_CPR: scale.counts_per_rev   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ENC; i++) begin
        counts[i] <= '0;
      end
    end else if (evt_acc) begin
      for (int i = 0; i < NUM_ENC; i++) begin
        if (evt.mode == MODE_TICK) begin
          snap[i]   <= counts[i];
          counts[i] <= '0;
        end else if ((evt.mode == MODE_EDGE_A || evt.mode == MODE_EDGE_B) &&
                     evt.channel == 2'(i)) begin
          counts[i] <= counts[i] + delta;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      start     <= 1'b0;
      ch_idx    <= '0;
      spd_valid <= 1'b0;
    end else begin
      start <= (state == T_START);
      if (state == T_OUT && (!spd_valid || spd_ready)) begin
        spd.speed_0 <= res[0];
        spd.speed_1 <= res[1];
        spd.speed_2 <= res[2];
        spd_valid   <= 1'b1;
      end else if (spd_valid && spd_ready) begin
        spd_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (evt_acc && evt.mode == MODE_TICK) begin
            ch_idx <= '0;
            state  <= T_START;
          end
        end
        T_START: begin
          state <= T_WAIT;
        end
        T_WAIT: begin
          if (unit_done) begin
            for (int i = 0; i < NUM_ENC; i++) begin
              if (ch_idx == CH_W'(i)) begin
                res[i] <= unit_speed;
              end
            end
            if (ch_idx == CH_LAST) begin
              state <= T_OUT;
            end else begin
              ch_idx <= ch_idx + CH_W'(1);
              state  <= T_START;
            end
          end
        end
        T_OUT: begin
          if (!spd_valid || spd_ready) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  qerc_speed_unit #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_speed (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .count (snap[ch_idx]),
    .scale (scale),
    .done  (unit_done),
    .speed (unit_speed)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import qerc_pkg::*;

  localparam int CW = COUNT_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] CHAN_NONE = 2'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_3 = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic evt_valid;
  logic evt_ready;
  evt_item_t evt;
  logic spd_valid;
  logic spd_ready = 1'b0;
  spd_item_t spd;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [SCALE_WIDTH-1:0] cfg_data;

  // local copy of block state
  logic signed [CW-1:0] enc_count [NUM_ENC];
  logic [SCALE_WIDTH-1:0] scale_tpm;
  logic [SCALE_WIDTH-1:0] scale_cpr;
  spd_item_t expected_speeds [$];

  // quadrature line state for well-formed traffic
  logic line_a [NUM_ENC];
  logic line_b [NUM_ENC];
  logic run_reverse [NUM_ENC];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int items_sent = 0;
  int speeds_seen = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  quad_encoder_rpm_counter_top uut (
    .clk(clk),
    .rst(rst),
    .evt_valid(evt_valid),
    .evt_ready(evt_ready),
    .evt(evt),
    .spd_valid(spd_valid),
    .spd_ready(spd_ready),
    .spd(spd),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk) begin
    spd_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 40)
      $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  function automatic logic signed [SPEED_WIDTH-1:0] rpm_of(input logic signed [CW-1:0] cnt);
    logic neg;
    logic [CW-1:0] u;
    logic [CW-1:0] m;
    logic [63:0] mag;
    logic [63:0] q;
    u = cnt;
    neg = u[CW-1];
    m = neg ? (~u + 1'b1) : u;
    mag = 64'(m);
    if (mag == 64'd0) return '0;
    if (scale_cpr == '0) return neg ? SPEED_NEG_SAT : SPEED_POS_SAT;
    q = (mag * 64'(scale_tpm)) / 64'(scale_cpr);
    if (neg) begin
      if (q >= 64'd32768) return SPEED_NEG_SAT;
      return -$signed(q[SPEED_WIDTH-1:0]);
    end
    if (q > 64'd32767) return SPEED_POS_SAT;
    return q[SPEED_WIDTH-1:0];
  endfunction

  task automatic predict_event(input evt_item_t it);
    spd_item_t s;
    logic up;
    if (it.mode == MODE_TICK) begin
      s.speed_0 = rpm_of(enc_count[0]);
      s.speed_1 = rpm_of(enc_count[1]);
      s.speed_2 = rpm_of(enc_count[2]);
      expected_speeds.push_back(s);
      for (int i = 0; i < NUM_ENC; i++) enc_count[i] = '0;
    end else if (it.mode != MODE_UNUSED && it.channel != CHAN_NONE) begin
      up = (it.mode == MODE_EDGE_A) ? (it.level_a == it.level_b) : (it.level_a != it.level_b);
      if (up) enc_count[it.channel] = enc_count[it.channel] + 1'b1;
      else enc_count[it.channel] = enc_count[it.channel] - 1'b1;
    end
  endtask

  always @(posedge clk) begin : check_speeds
    spd_item_t want;
    if (!rst && spd_valid && spd_ready) begin
      speeds_seen++;
      if (expected_speeds.size() == 0) begin
        report_mismatch("unexpected result, speed_0", int'(spd.speed_0), 0);
      end else begin
        want = expected_speeds.pop_front();
        if (spd.speed_0 !== want.speed_0)
          report_mismatch("speed_0", int'(spd.speed_0), int'(want.speed_0));
        if (spd.speed_1 !== want.speed_1)
          report_mismatch("speed_1", int'(spd.speed_1), int'(want.speed_1));
        if (spd.speed_2 !== want.speed_2)
          report_mismatch("speed_2", int'(spd.speed_2), int'(want.speed_2));
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_item(input logic [1:0] mode, input logic [1:0] chan,
                           input logic a, input logic b);
    evt_item_t it;
    it.mode = mode;
    it.channel = chan;
    it.level_a = a;
    it.level_b = b;
    while ($urandom_range(99) < send_idle_pct) begin
      evt_valid <= 1'b0;
      @(negedge clk);
    end
    evt_valid <= 1'b1;
    evt <= it;
    @(posedge clk);
    while (!evt_ready) @(posedge clk);
    predict_event(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic stop_sending();
    evt_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    while (expected_speeds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [SCALE_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_TPM) scale_tpm = val;
    else if (idx == REG_CPR) scale_cpr = val;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_scale(input logic [SCALE_WIDTH-1:0] tpm, input logic [SCALE_WIDTH-1:0] cpr);
    wait_quiet();
    write_reg(REG_TPM, tpm);
    write_reg(REG_CPR, cpr);
  endtask

  // every edge kind and level pair, spread over the encoders
  task automatic test_edge_directions();
    int k;
    k = 0;
    for (int m = 0; m < 2; m++)
      for (int lv = 0; lv < 4; lv++) begin
        send_item(m[1:0], 2'(k % NUM_ENC), lv[1], lv[0]);
        k++;
      end
    send_item(MODE_EDGE_A, 2'd2, 1'b1, 1'b1);
    send_item(MODE_TICK, 2'd0, 1'b0, 1'b0);
    send_item(MODE_TICK, CHAN_NONE, 1'b1, 1'b1);
    stop_sending();
  endtask

  task automatic test_ignored_items();
    send_item(MODE_EDGE_B, 2'd0, 1'b1, 1'b0);
    send_item(MODE_UNUSED, 2'd1, 1'b1, 1'b1);
    send_item(MODE_EDGE_A, CHAN_NONE, 1'b0, 1'b0);
    send_item(MODE_EDGE_B, CHAN_NONE, 1'b1, 1'b0);
    send_item(MODE_TICK, 2'd1, 1'b0, 1'b1);
    stop_sending();
  endtask

  task automatic test_scale_extremes();
    wait_quiet();
    write_reg(REG_SPARE_2, 16'h0000);
    write_reg(REG_SPARE_3, 16'hFFFF);
    set_scale(16'd1000, 16'd0);
    send_item(MODE_EDGE_A, 2'd0, 1'b0, 1'b0);
    send_item(MODE_EDGE_A, 2'd1, 1'b1, 1'b0);
    send_item(MODE_TICK, 2'd0, 1'b0, 1'b0);
    stop_sending();
    set_scale(16'd0, 16'd1);
    send_item(MODE_EDGE_B, 2'd2, 1'b0, 1'b1);
    send_item(MODE_TICK, 2'd0, 1'b0, 1'b0);
    stop_sending();
    set_scale(16'hFFFF, 16'd1);
    send_item(MODE_EDGE_B, 2'd0, 1'b1, 1'b0);
    send_item(MODE_EDGE_B, 2'd1, 1'b1, 1'b1);
    send_item(MODE_TICK, 2'd0, 1'b0, 1'b0);
    stop_sending();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [SCALE_WIDTH-1:0] tpm,
                                     input logic [SCALE_WIDTH-1:0] cpr, input int n);
    int ch;
    logic [5:0] noise;
    set_scale(tpm, cpr);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    ch = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) begin
        send_item(MODE_TICK, 2'($urandom_range(3)), 1'($urandom), 1'($urandom));
      end else if ($urandom_range(99) < 80) begin
        // well-formed quadrature step, runs of one direction per encoder
        if ($urandom_range(3) == 0) ch = $urandom_range(NUM_ENC - 1);
        if ($urandom_range(19) == 0) run_reverse[ch] = ~run_reverse[ch];
        if ((line_a[ch] == line_b[ch]) != run_reverse[ch]) begin
          line_a[ch] = ~line_a[ch];
          send_item(MODE_EDGE_A, 2'(ch), line_a[ch], line_b[ch]);
        end else begin
          line_b[ch] = ~line_b[ch];
          send_item(MODE_EDGE_B, 2'(ch), line_a[ch], line_b[ch]);
        end
      end else begin
        noise = 6'($urandom);
        send_item(noise[5:4], noise[3:2], noise[1], noise[0]);
      end
    end
    stop_sending();
  endtask

  initial begin
    rst = 1'b1;
    evt_valid = 1'b0;
    evt = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    scale_tpm = TPM_RESET;
    scale_cpr = CPR_RESET;
    for (int i = 0; i < NUM_ENC; i++) begin
      enc_count[i] = '0;
      line_a[i] = 1'b0;
      line_b[i] = 1'b0;
      run_reverse[i] = 1'($urandom);
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_edge_directions();
    test_ignored_items();
    test_scale_extremes();

    test_random_traffic(0, 0, TPM_RESET, CPR_RESET, 125);
    test_random_traffic(0, 0, 16'hFFFF, 16'd1, 125);
    test_random_traffic(49, 0, 16'd1, 16'hFFFF, 125);
    test_random_traffic(49, 0, 16'($urandom), 16'($urandom_range(65535, 1)), 125);
    test_random_traffic(0, 49, 16'd0, 16'($urandom), 125);
    test_random_traffic(0, 49, 16'($urandom), 16'd0, 125);
    test_random_traffic(8, 8, 16'($urandom), 16'($urandom_range(16, 1)), 125);
    test_random_traffic(8, 8, 16'($urandom), 16'($urandom), 125);

    wait_quiet();
    repeat (200) @(posedge clk);
    $display("sent %0d event items, checked %0d speed results, %0d register writes",
             items_sent, speeds_seen, reg_writes);
    $display("traffic ran with sender gaps, receiver stalls and scale extremes");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
